/* hw/rtl/bod_pkg.sv */
// ----------------------------------------------------------------------------
// bod_pkg
// Shared types, register indexes and dither matrices for the ordered dither
// pixel block.
// ----------------------------------------------------------------------------
package bod_pkg;

   // luminance weights, 16 fraction bits
   localparam logic [15:0] COEF_RED   = 16'd13938;
   localparam logic [15:0] COEF_GREEN = 16'd46869;
   localparam logic [15:0] COEF_BLUE  = 16'd4730;

   // field widths
   localparam int unsigned COORD_W = 12;
   localparam int unsigned CHAN_W  = 8;
   localparam int unsigned PROD_W  = 24;   // coefficient times channel
   localparam int unsigned LUM_W   = 24;   // sum of three products
   localparam int unsigned FACT_W  = 7;    // n + entry, at most 127
   localparam int unsigned RHS_W   = 30;   // threshold << 16 times n
   localparam int unsigned LHS_W   = 31;   // luminance times (n + entry)

   // configuration port
   localparam int unsigned CSR_IDX_W = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MATRIX_SELECT   = 2'd0,
      CSR_WHITE_THRESHOLD = 2'd1
   } csr_index_type;

   typedef enum logic [1:0] {
      MAT_2X2 = 2'd0,
      MAT_4X4 = 2'd1,
      MAT_8X8 = 2'd2
   } matrix_type;

   // output levels
   localparam logic [CHAN_W-1:0] GRAY_WHITE = 8'd255;
   localparam logic [CHAN_W-1:0] GRAY_BLACK = 8'd0;

   // item payloads
   typedef struct packed {
      logic [COORD_W-1:0] column;
      logic [COORD_W-1:0] row;
      logic [CHAN_W-1:0]  red;
      logic [CHAN_W-1:0]  green;
      logic [CHAN_W-1:0]  blue;
      logic [CHAN_W-1:0]  alpha_in;
   } req_type;

   typedef struct packed {
      logic [CHAN_W-1:0] gray_level;
      logic [CHAN_W-1:0] alpha_out;
   } rsp_type;

   // bayer matrices, indexed [row][column]
   localparam logic [1:0] BAYER2 [2][2] = '{
      '{2'd0, 2'd3},
      '{2'd2, 2'd1}
   };

   localparam logic [3:0] BAYER4 [4][4] = '{
      '{4'd0,  4'd8,  4'd2,  4'd10},
      '{4'd12, 4'd4,  4'd14, 4'd6},
      '{4'd3,  4'd11, 4'd1,  4'd9},
      '{4'd15, 4'd7,  4'd13, 4'd5}
   };

   localparam logic [5:0] BAYER8 [8][8] = '{
      '{6'd0,  6'd32, 6'd8,  6'd40, 6'd2,  6'd34, 6'd10, 6'd42},
      '{6'd48, 6'd16, 6'd56, 6'd24, 6'd50, 6'd18, 6'd58, 6'd26},
      '{6'd12, 6'd44, 6'd4,  6'd36, 6'd14, 6'd46, 6'd6,  6'd38},
      '{6'd60, 6'd28, 6'd52, 6'd20, 6'd62, 6'd30, 6'd54, 6'd22},
      '{6'd3,  6'd35, 6'd11, 6'd43, 6'd1,  6'd33, 6'd9,  6'd41},
      '{6'd51, 6'd19, 6'd59, 6'd27, 6'd49, 6'd17, 6'd57, 6'd25},
      '{6'd15, 6'd47, 6'd7,  6'd39, 6'd13, 6'd45, 6'd5,  6'd37},
      '{6'd63, 6'd31, 6'd55, 6'd23, 6'd61, 6'd29, 6'd53, 6'd21}
   };

endpackage

/* hw/rtl/bayer_ordered_dither_pixel.sv */
// ----------------------------------------------------------------------------
// bayer_ordered_dither_pixel
// Ordered dither of one pixel to black or white using a 2x2, 4x4 or 8x8
// bayer matrix on its fixed point luminance; alpha passes through.
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake          payload
//   req_     in   req_valid/stall    bod_pkg::req_type (coordinates, rgba)
//   rsp_     out  rsp_valid/stall    bod_pkg::rsp_type (gray, alpha)
//   csr_     in   csr_valid/ready    csr_index, csr_wdata
//
// Four register stages: channel products, luminance sum, dither scaling,
// compare into the output register. One item per clock while no rsp_stall
// holds the pipe; an item moves through the product, luminance, scaling and
// output registers in that order, and rsp_valid rises as it reaches the last.
// Reset clears the stage valid bits and loads matrix_select = 8x8,
// white_threshold = 128. Under rsp_stall the output register holds and empty
// stages behind it keep filling; req_stall rises only when every stage holds an item.
//
module bayer_ordered_dither_pixel (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_stall,
   input  bod_pkg::req_type                  req_data,

   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output bod_pkg::rsp_type                  rsp_data,

   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bod_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bod_pkg::CHAN_W-1:0]        csr_wdata
);

   // configuration registers
   logic [1:0]                    matrix_select_ff;
   logic [bod_pkg::CHAN_W-1:0]    white_threshold_ff;

   // stage valids
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic v1_in, v2_in, v3_in, v4_in;
   logic adv1, adv2, adv3, adv4;

   // stage 1: products, dither factor, threshold
   logic [bod_pkg::PROD_W-1:0]  prod_r_ff, prod_g_ff, prod_b_ff;
   logic [bod_pkg::PROD_W-1:0]  prod_r_in, prod_g_in, prod_b_in;
   logic [bod_pkg::FACT_W-1:0]  fact1_ff, fact1_in;
   logic [bod_pkg::RHS_W-1:0]   rhs1_ff, rhs1_in;
   logic [bod_pkg::CHAN_W-1:0]  alpha1_ff;

   // stage 2: luminance
   logic [bod_pkg::LUM_W-1:0]   lum_ff, lum_in;
   logic [bod_pkg::FACT_W-1:0]  fact2_ff;
   logic [bod_pkg::RHS_W-1:0]   rhs2_ff;
   logic [bod_pkg::CHAN_W-1:0]  alpha2_ff;

   // stage 3: scaled luminance
   logic [bod_pkg::LHS_W-1:0]   lhs_ff, lhs_in;
   logic [bod_pkg::RHS_W-1:0]   rhs3_ff;
   logic [bod_pkg::CHAN_W-1:0]  alpha3_ff;

   // stage 4: output register
   bod_pkg::rsp_type            rsp_ff, rsp_in;

   // config writes, always accepted
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         matrix_select_ff   <= bod_pkg::MAT_8X8;
         white_threshold_ff <= 8'd128;
      end else if (csr_valid) begin
         unique case (csr_index)
            bod_pkg::CSR_MATRIX_SELECT:   matrix_select_ff   <= csr_wdata[1:0];
            bod_pkg::CSR_WHITE_THRESHOLD: white_threshold_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // pipeline advance, from the output back
   assign adv4 = !v4_ff || !rsp_stall;
   assign adv3 = !v3_ff || adv4;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;

   assign v1_in = adv1 ? req_valid : v1_ff;
   assign v2_in = adv2 ? v1_ff : v2_ff;
   assign v3_in = adv3 ? v2_ff : v3_ff;
   assign v4_in = adv4 ? v3_ff : v4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   // stage 1 logic: weighted channels, matrix entry and threshold
   assign prod_r_in = bod_pkg::PROD_W'(bod_pkg::COEF_RED)
                      * bod_pkg::PROD_W'(req_data.red);
   assign prod_g_in = bod_pkg::PROD_W'(bod_pkg::COEF_GREEN)
                      * bod_pkg::PROD_W'(req_data.green);
   assign prod_b_in = bod_pkg::PROD_W'(bod_pkg::COEF_BLUE)
                      * bod_pkg::PROD_W'(req_data.blue);

   always_comb begin
      unique case (matrix_select_ff)
         bod_pkg::MAT_2X2: begin
            fact1_in = 7'd4 + 7'(bod_pkg::BAYER2[req_data.row[0]][req_data.column[0]]);
            rhs1_in  = 30'({white_threshold_ff, 18'd0});
         end
         bod_pkg::MAT_4X4: begin
            fact1_in = 7'd16
                       + 7'(bod_pkg::BAYER4[req_data.row[1:0]][req_data.column[1:0]]);
            rhs1_in  = 30'({white_threshold_ff, 20'd0});
         end
         default: begin
            // 8x8, also for the unused select code
            fact1_in = 7'd64
                       + 7'(bod_pkg::BAYER8[req_data.row[2:0]][req_data.column[2:0]]);
            rhs1_in  = {white_threshold_ff, 22'd0};
         end
      endcase
   end

   // stage 2 logic: luminance sum
   assign lum_in = bod_pkg::LUM_W'(prod_r_ff + prod_g_ff + prod_b_ff);

   // stage 3 logic: scale by n + entry
   assign lhs_in = bod_pkg::LHS_W'(lum_ff) * bod_pkg::LHS_W'(fact2_ff);

   // stage 4 logic: threshold compare
   always_comb begin
      rsp_in.gray_level = (lhs_ff >= bod_pkg::LHS_W'(rhs3_ff)) ? bod_pkg::GRAY_WHITE
                                                               : bod_pkg::GRAY_BLACK;
      rsp_in.alpha_out  = alpha3_ff;
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (adv1) begin
         prod_r_ff <= prod_r_in;
         prod_g_ff <= prod_g_in;
         prod_b_ff <= prod_b_in;
         fact1_ff  <= fact1_in;
         rhs1_ff   <= rhs1_in;
         alpha1_ff <= req_data.alpha_in;
      end
      if (adv2) begin
         lum_ff    <= lum_in;
         fact2_ff  <= fact1_ff;
         rhs2_ff   <= rhs1_ff;
         alpha2_ff <= alpha1_ff;
      end
      if (adv3) begin
         lhs_ff    <= lhs_in;
         rhs3_ff   <= rhs2_ff;
         alpha3_ff <= alpha2_ff;
      end
      if (adv4) begin
         rsp_ff    <= rsp_in;
      end
   end

   // ports
   assign req_stall = !adv1;
   assign rsp_valid = v4_ff;
   assign rsp_data  = rsp_ff;

endmodule
